FILE: design/tes_pkg.sv
// tes_pkg: shared constants for the triangle element stiffness unit.
// No dependencies; used by every module of the block.
`default_nettype none
package tes_pkg;

  localparam int LAMBDA_WIDTH = 24;
  localparam logic [LAMBDA_WIDTH-1:0] LAMBDA_RESET = 24'd65536;  // 1.0 in Q8.16

  localparam int NUM_ENTRIES = 6;
  // upper-triangle entry order: k00, k01, k02, k11, k12, k22
  localparam int ROW [NUM_ENTRIES] = '{0, 0, 0, 1, 1, 2};
  localparam int COL [NUM_ENTRIES] = '{0, 1, 2, 1, 2, 2};

  localparam int USER_WIDTH = 8;
  localparam int USER_DEGEN = 0;
  localparam int USER_SAT   = 1;

endpackage
`default_nettype wire

FILE: design/triangle_element_stiffness_unit.sv
// triangle_element_stiffness_unit: P1 triangle conductivity matrix, six entries.
// Pipeline: six front stages, one divider stage per quotient bit
// (2*COORD_WIDTH+27), one output stage.
// Throughput: one transaction per cycle; stalls collapse bubbles stage by stage.
// Reset (rst, synchronous): pipeline empties, conductivity returns to 1.0.
// Depends on tes_pkg, tes_front, tes_div_stage, tes_out.
`default_nettype none
module triangle_element_stiffness_unit #(
  parameter int COORD_WIDTH = 24,
  parameter int OUT_WIDTH   = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  // x0, y0, x1, y1, x2, y2 from bit 0 up, zero padded
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // k00, k01, k02, k11, k12, k22 from bit 0 up, zero padded
  output logic [((6*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // degenerate, saturated from bit 0 up, zero padded
  output logic [tes_pkg::USER_WIDTH-1:0] m_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  input  wire logic [tes_pkg::LAMBDA_WIDTH-1:0] cfg_data,
  input  wire logic cfg_valid,
  output logic      cfg_ready
);
  localparam int NB = 2 * COORD_WIDTH + 27;
  localparam int RB = 2 * COORD_WIDTH + 4;
  localparam int AW = RB + NB;
  localparam int NE = tes_pkg::NUM_ENTRIES;
  localparam int OTD = ((6 * OUT_WIDTH + 7) / 8) * 8;

  logic [tes_pkg::LAMBDA_WIDTH-1:0] lambda;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda <= tes_pkg::LAMBDA_RESET;
    end else if (cfg_valid) begin
      lambda <= cfg_data;
    end
  end

  logic [5:0][COORD_WIDTH-1:0] coord;
  assign coord = s_axis_tdata[6*COORD_WIDTH-1:0];

  logic [NE-1:0][NB-1:0] f_num;

  logic [NB:0]                 dv;
  logic [NB:0]                 dr;
  logic [NB:0][NE-1:0][AW-1:0] dacc;
  logic [NB:0][RB-1:0]         dden;
  logic [NB:0][NE-1:0]         dneg;
  logic [NB:0]                 ddg;

  tes_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .coord(coord), .lambda(lambda),
    .out_valid(dv[0]), .out_ready(dr[0]),
    .num(f_num), .den(dden[0]), .neg(dneg[0]), .degen(ddg[0])
  );

  for (genvar k = 0; k < NE; k++) begin : g_init
    assign dacc[0][k] = {{RB{1'b0}}, f_num[k]};
  end

  for (genvar s = 0; s < NB; s++) begin : g_div
    tes_div_stage #(.COORD_WIDTH(COORD_WIDTH)) u_stage (
      .clk(clk), .rst(rst),
      .in_valid(dv[s]), .in_ready(dr[s]),
      .in_acc(dacc[s]), .in_den(dden[s]), .in_neg(dneg[s]), .in_degen(ddg[s]),
      .out_valid(dv[s+1]), .out_ready(dr[s+1]),
      .out_acc(dacc[s+1]), .out_den(dden[s+1]), .out_neg(dneg[s+1]),
      .out_degen(ddg[s+1])
    );
  end

  logic [NE-1:0][NB-1:0] quo;
  for (genvar k = 0; k < NE; k++) begin : g_quo
    assign quo[k] = dacc[NB][k][NB-1:0];
  end

  logic [NE-1:0][OUT_WIDTH-1:0] entries;
  logic degen, sat;

  tes_out #(.COORD_WIDTH(COORD_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_out (
    .clk(clk), .rst(rst),
    .in_valid(dv[NB]), .in_ready(dr[NB]),
    .quo(quo), .neg(dneg[NB]), .degen_in(ddg[NB]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .entries(entries), .degen(degen), .sat(sat)
  );

  assign m_axis_tdata = OTD'(entries);
  assign m_axis_tuser = tes_pkg::USER_WIDTH'({sat, degen});

  a_degen_no_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[tes_pkg::USER_DEGEN] |-> !m_axis_tuser[tes_pkg::USER_SAT])
    else $error("saturation flagged on a zero-area element");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[tes_pkg::USER_DEGEN] |-> m_axis_tdata == '0)
    else $error("nonzero entries on a zero-area element");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

FILE: design/tes_front.sv
// tes_front: six-stage front end: edge differences, products, area, magnitudes,
// conductivity scaling and rounded numerator. Depends on tes_pkg.
`default_nettype none
module tes_front #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [5:0][COORD_WIDTH-1:0]           coord,
  input  wire logic [tes_pkg::LAMBDA_WIDTH-1:0]      lambda,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [tes_pkg::NUM_ENTRIES-1:0][2*COORD_WIDTH+26:0] num,
  output logic [2*COORD_WIDTH+3:0]                   den,
  output logic [tes_pkg::NUM_ENTRIES-1:0]            neg,
  output logic                                       degen
);
  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 3;
  localparam int MW = 2 * W + 2;
  localparam int HW = MW / 2;
  localparam int LW = tes_pkg::LAMBDA_WIDTH;
  localparam int NB = 2 * W + 27;
  localparam int RB = 2 * W + 4;
  localparam int NE = tes_pkg::NUM_ENTRIES;

  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6 || out_ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  logic signed [DW-1:0] xs [3];
  logic signed [DW-1:0] ys [3];
  logic signed [DW-1:0] b [3];
  logic signed [DW-1:0] c [3];
  logic signed [PW-1:0] bb [NE];
  logic signed [PW-1:0] cc [NE];
  logic signed [PW-1:0] tp, tq;
  logic signed [SW-1:0] dd [NE];
  logic signed [SW-1:0] t;
  logic [MW-1:0] mag [NE];
  logic [NE-1:0] ng4, ng5;
  logic [MW-1:0] tabs4, tabs5;
  logic dg4, dg5;
  logic [HW+LW-1:0] plo [NE];
  logic [MW-HW+LW-1:0] phi [NE];

  for (genvar i = 0; i < 3; i++) begin : g_ext
    assign xs[i] = DW'(signed'(coord[2*i]));
    assign ys[i] = DW'(signed'(coord[2*i+1]));
  end

  // stage 1: gradient differences
  always_ff @(posedge clk) begin
    if (rdy1) begin
      b[0] <= ys[1] - ys[2];
      b[1] <= ys[2] - ys[0];
      b[2] <= ys[0] - ys[1];
      c[0] <= xs[2] - xs[1];
      c[1] <= xs[0] - xs[2];
      c[2] <= xs[1] - xs[0];
    end
  end

  // stage 2: products; twice the area is c2*b1 - c1*b2
  for (genvar k = 0; k < NE; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (rdy2) begin
        bb[k] <= b[tes_pkg::ROW[k]] * b[tes_pkg::COL[k]];
        cc[k] <= c[tes_pkg::ROW[k]] * c[tes_pkg::COL[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      tp <= c[2] * b[1];
      tq <= c[1] * b[2];
    end
  end

  // stage 3: sums
  for (genvar k = 0; k < NE; k++) begin : g_sum
    always_ff @(posedge clk) begin
      if (rdy3) dd[k] <= SW'(bb[k]) + SW'(cc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) t <= SW'(tp) - SW'(tq);
  end

  // stage 4: magnitudes and signs
  for (genvar k = 0; k < NE; k++) begin : g_abs
    always_ff @(posedge clk) begin
      if (rdy4) begin
        mag[k] <= MW'(dd[k][SW-1] ? -dd[k] : dd[k]);
        ng4[k] <= dd[k][SW-1] ^ t[SW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      tabs4 <= MW'(t[SW-1] ? -t : t);
      dg4   <= (t == '0);
    end
  end

  // stage 5: split multiply by lambda
  for (genvar k = 0; k < NE; k++) begin : g_mul
    always_ff @(posedge clk) begin
      if (rdy5) begin
        plo[k] <= mag[k][HW-1:0] * lambda;
        phi[k] <= mag[k][MW-1:HW] * lambda;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      tabs5 <= tabs4;
      ng5   <= ng4;
      dg5   <= dg4;
    end
  end

  // stage 6: numerator with half the divisor added for rounding
  for (genvar k = 0; k < NE; k++) begin : g_num
    always_ff @(posedge clk) begin
      if (rdy6) num[k] <= (NB'(phi[k]) << HW) + NB'(plo[k]) + NB'(tabs5);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      den   <= RB'({tabs5, 1'b0});
      neg   <= ng5;
      degen <= dg5;
    end
  end

endmodule
`default_nettype wire

FILE: design/tes_div_stage.sv
// tes_div_stage: one restoring-division bit for all six entries.
// Depends on tes_pkg; chained by the top level into the divider pipeline.
`default_nettype none
module tes_div_stage #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [tes_pkg::NUM_ENTRIES-1:0][4*COORD_WIDTH+30:0] in_acc,
  input  wire logic [2*COORD_WIDTH+3:0]              in_den,
  input  wire logic [tes_pkg::NUM_ENTRIES-1:0]       in_neg,
  input  wire logic                                  in_degen,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [tes_pkg::NUM_ENTRIES-1:0][4*COORD_WIDTH+30:0] out_acc,
  output logic [2*COORD_WIDTH+3:0]                   out_den,
  output logic [tes_pkg::NUM_ENTRIES-1:0]            out_neg,
  output logic                                       out_degen
);
  localparam int NB = 2 * COORD_WIDTH + 27;
  localparam int RB = 2 * COORD_WIDTH + 4;
  localparam int AW = RB + NB;
  localparam int NE = tes_pkg::NUM_ENTRIES;

  logic v;
  logic [NE-1:0][AW-1:0] acc_next;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  // acc holds {remainder, unconsumed numerator bits, quotient bits}
  for (genvar k = 0; k < NE; k++) begin : g_lane
    logic [RB:0] trial;
    logic [RB:0] diff;
    logic        ge;
    assign trial = {in_acc[k][AW-1:NB], in_acc[k][NB-1]};
    assign ge    = trial >= {1'b0, in_den};
    assign diff  = trial - {1'b0, in_den};
    assign acc_next[k] = ge ? {diff[RB-1:0], in_acc[k][NB-2:0], 1'b1}
                            : {trial[RB-1:0], in_acc[k][NB-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_acc   <= acc_next;
      out_den   <= in_den;
      out_neg   <= in_neg;
      out_degen <= in_degen;
    end
  end

endmodule
`default_nettype wire

FILE: design/tes_out.sv
// tes_out: sign, saturation and zero-area handling; output register.
// Depends on tes_pkg.
`default_nettype none
module tes_out #(
  parameter int COORD_WIDTH = 24,
  parameter int OUT_WIDTH   = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [tes_pkg::NUM_ENTRIES-1:0][2*COORD_WIDTH+26:0] quo,
  input  wire logic [tes_pkg::NUM_ENTRIES-1:0]       neg,
  input  wire logic                                  degen_in,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [tes_pkg::NUM_ENTRIES-1:0][OUT_WIDTH-1:0] entries,
  output logic                                       degen,
  output logic                                       sat
);
  localparam int NB = 2 * COORD_WIDTH + 27;
  localparam int CW = ((NB > OUT_WIDTH) ? NB : OUT_WIDTH) + 1;
  localparam int NE = tes_pkg::NUM_ENTRIES;

  logic v;
  logic [NE-1:0][OUT_WIDTH-1:0] entries_next;
  logic [NE-1:0] lane_sat;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  for (genvar k = 0; k < NE; k++) begin : g_lane
    logic [CW-1:0] qx, lim, mag, sgn;
    assign qx  = CW'(quo[k]);
    assign lim = neg[k] ? (CW'(1) << (OUT_WIDTH - 1)) : ((CW'(1) << (OUT_WIDTH - 1)) - CW'(1));
    assign lane_sat[k] = qx > lim;
    assign mag = lane_sat[k] ? lim : qx;
    assign sgn = neg[k] ? -mag : mag;
    assign entries_next[k] = degen_in ? '0 : sgn[OUT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      entries <= entries_next;
      degen   <= degen_in;
      sat     <= !degen_in && (|lane_sat);
    end
  end

endmodule
`default_nettype wire
